FILE: design/tip_pkg.sv
// shared types and constants for the text integer parser
`timescale 1ns / 1ps
`default_nettype none

package tip_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEX_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_LIMIT = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
  localparam logic [DIGIT_W-1:0] HEX_LETTER_BASE = 4'd10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    PH_SKIP_LEAD = 2'd0,
    PH_SKIP_SIGN = 2'd1,
    PH_DIGITS    = 2'd2
  } phase_t;

  typedef struct packed {
    logic               hex_mode;
    logic               signed_mode;
    logic [COUNT_W-1:0] digit_limit;
  } cfg_t;

  typedef struct packed {
    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
    logic               is_space;
    logic               is_minus;
  } char_class_t;

  typedef struct packed {
    logic               char_consumed;
    logic               number_done;
    logic [VALUE_W-1:0] number_value;
    logic               number_ok;
    logic               fail_sticky;
  } result_t;

endpackage

`default_nettype wire

FILE: design/tip_char_if.sv
// character input channel
`timescale 1ns / 1ps
`default_nettype none

interface tip_char_if
  import tip_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              is_last_char;

  modport source (output valid, output char_code, output is_last_char, input ready);
  modport sink   (input valid, input char_code, input is_last_char, output ready);
endinterface

`default_nettype wire

FILE: design/tip_result_if.sv
// parse result output channel
`timescale 1ns / 1ps
`default_nettype none

interface tip_result_if
  import tip_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               char_consumed;
  logic               number_done;
  logic [VALUE_W-1:0] number_value;
  logic               number_ok;
  logic               fail_sticky;

  modport source (output valid, output char_consumed, output number_done,
                  output number_value, output number_ok, output fail_sticky,
                  input ready);
  modport sink   (input valid, input char_consumed, input number_done,
                  input number_value, input number_ok, input fail_sticky,
                  output ready);
endinterface

`default_nettype wire

FILE: design/text_integer_parser_core.sv
// top level of the text integer parser
//
// streaming ascii integer parser, one character word per cycle
// - chars: character words (char_code, is_last_char), valid/ready
// - results: one result word per character word, valid/ready
// - cfg_we/cfg_index/cfg_data: register writes (0 hex_mode, 1 signed_mode,
//   2 digit_limit); write only while the block is idle
// latency: a result word appears one cycle after its character is taken
// throughput: one character per cycle; the parse state and the result
//   register both update on the accept edge, so words may follow back to back
// the result register decouples the two sides: a new character is taken
// whenever the register is empty or its word is taken in the same cycle
// stall: when the receiver holds ready low, the result word is held and
//   chars.ready drops until it is taken
// reset: synchronous, clears phase, accumulator, count, fail flag,
//   configuration and the result valid bit; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module text_integer_parser_core
  import tip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  tip_char_if.sink              chars,
  tip_result_if.source          results,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t        cfg;
  char_class_t cls;
  result_t     step_res;
  result_t     out_word;
  logic        out_valid;
  logic        accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEX_MODE:    cfg.hex_mode    <= cfg_data[0];
        REG_SIGNED_MODE: cfg.signed_mode <= cfg_data[0];
        REG_DIGIT_LIMIT: cfg.digit_limit <= cfg_data[COUNT_W-1:0];
        default: ; // unmapped index, ignored
      endcase
    end
  end

  // take a character when the result slot is free or being emptied
  assign chars.ready = !out_valid || results.ready;
  assign accept      = chars.valid && chars.ready;

  tip_classify u_classify (
    .char_code (chars.char_code),
    .hex_mode  (cfg.hex_mode),
    .cls       (cls)
  );

  tip_step u_step (
    .clk          (clk),
    .rst          (rst),
    .advance      (accept),
    .is_last_char (chars.is_last_char),
    .cfg          (cfg),
    .cls          (cls),
    .res          (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_word <= step_res;
    end
  end

  assign results.valid         = out_valid;
  assign results.char_consumed = out_word.char_consumed;
  assign results.number_done   = out_word.number_done;
  assign results.number_value  = out_word.number_value;
  assign results.number_ok     = out_word.number_ok;
  assign results.fail_sticky   = out_word.fail_sticky;

endmodule

`default_nettype wire

FILE: design/tip_classify.sv
// character classifier: digit value, space and minus detection
`timescale 1ns / 1ps
`default_nettype none

module tip_classify
  import tip_pkg::*;
(
  input  logic [CHAR_W-1:0] char_code,
  input  logic              hex_mode,
  output char_class_t       cls
);

  logic [CHAR_W-1:0] off_num;
  logic [CHAR_W-1:0] off_lo;
  logic [CHAR_W-1:0] off_up;

  assign off_num = char_code - CH_ZERO;
  assign off_lo  = char_code - CH_LO_A;
  assign off_up  = char_code - CH_UP_A;

  always_comb begin
    cls.is_digit = 1'b0;
    cls.digit    = '0;
    cls.is_space = (char_code == CH_SPACE);
    cls.is_minus = (char_code == CH_MINUS);
    if (char_code inside {[CH_ZERO:CH_NINE]}) begin
      cls.is_digit = 1'b1;
      cls.digit    = off_num[DIGIT_W-1:0];
    end else if (hex_mode && (char_code inside {[CH_LO_A:CH_LO_F]})) begin
      cls.is_digit = 1'b1;
      cls.digit    = off_lo[DIGIT_W-1:0] + HEX_LETTER_BASE;
    end else if (hex_mode && (char_code inside {[CH_UP_A:CH_UP_F]})) begin
      cls.is_digit = 1'b1;
      cls.digit    = off_up[DIGIT_W-1:0] + HEX_LETTER_BASE;
    end
  end

endmodule

`default_nettype wire

FILE: design/tip_step.sv
// parse state machine: phase, accumulator, digit count and fail flag
`timescale 1ns / 1ps
`default_nettype none

module tip_step
  import tip_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        is_last_char,
  input  cfg_t        cfg,
  input  char_class_t cls,
  output result_t     res
);

  phase_t             phase, phase_next;
  logic [VALUE_W-1:0] acc, acc_next;
  logic [COUNT_W-1:0] count, count_next;
  logic               neg, neg_next;
  logic               fail, fail_next;

  logic               skipping;
  logic               take_space;
  logic               take_minus;
  logic               handled;
  logic               take_digit;
  logic               done;
  logic [COUNT_W-1:0] count_inc;
  logic [VALUE_W-1:0] acc_mul;
  logic [VALUE_W-1:0] acc_dig;
  logic               limit_hit;

  assign skipping   = (phase == PH_SKIP_LEAD) || (phase == PH_SKIP_SIGN);
  assign take_space = skipping && cls.is_space;
  assign take_minus = (phase == PH_SKIP_LEAD) && cfg.signed_mode && cls.is_minus
                      && !cls.is_space;
  assign handled    = take_space || take_minus;
  assign take_digit = !handled && cls.is_digit;

  assign count_inc = (count == COUNT_MAX) ? count : count + 1'b1;
  // times 16, or times 10 as 8x + 2x
  assign acc_mul   = cfg.hex_mode ? {acc[VALUE_W-5:0], 4'b0}
                                  : ({acc[VALUE_W-4:0], 3'b0} + {acc[VALUE_W-2:0], 1'b0});
  assign acc_dig   = acc_mul + VALUE_W'(cls.digit);
  assign limit_hit = (cfg.digit_limit != '0) && (count_inc >= cfg.digit_limit);

  // result for the current word
  always_comb begin
    res  = '0;
    done = 1'b0;
    if (handled) begin
      res.char_consumed = 1'b1;
      done              = is_last_char;
    end else if (take_digit) begin
      res.char_consumed = 1'b1;
      done              = is_last_char || limit_hit;
      res.number_ok     = done;
      if (done) begin
        res.number_value = neg ? (VALUE_W'(0) - acc_dig) : acc_dig;
      end
    end else begin
      // non-digit ends the number and is left in the stream
      done             = 1'b1;
      res.number_ok    = (count != '0);
      res.number_value = neg ? (VALUE_W'(0) - acc) : acc;
    end
    res.number_done = done;
    fail_next       = fail || (handled && is_last_char) ||
                      (!handled && !take_digit && (count == '0));
    res.fail_sticky = fail_next;
  end

  // next parse state
  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    count_next = count;
    neg_next   = neg;
    if (done) begin
      phase_next = PH_SKIP_LEAD;
      acc_next   = '0;
      count_next = '0;
      neg_next   = 1'b0;
    end else if (take_minus) begin
      phase_next = PH_SKIP_SIGN;
      neg_next   = 1'b1;
    end else if (take_digit) begin
      phase_next = PH_DIGITS;
      acc_next   = acc_dig;
      count_next = count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SKIP_LEAD;
      acc   <= '0;
      count <= '0;
      neg   <= 1'b0;
      fail  <= 1'b0;
    end else if (advance) begin
      phase <= phase_next;
      acc   <= acc_next;
      count <= count_next;
      neg   <= neg_next;
      fail  <= fail_next;
    end
  end

endmodule

`default_nettype wire
